// ----- sv/kcvt_pkg.sv -----
package kcvt_pkg;

  localparam int WORD_BITS   = 32;
  localparam int DT_BITS     = 16;
  localparam int GAIN_BITS   = 32;
  localparam int RECIP_SHIFT = 126;
  localparam int WIDE_BITS   = 66;   // signed working width for sums
  localparam int PROD_BITS   = 128;
  localparam int OPND_BITS   = 64;
  localparam int MUL_DIGIT   = 8;    // multiplier bits consumed per cycle
  localparam int MUL_STEPS   = OPND_BITS / MUL_DIGIT;
  localparam int DIV_STEPS   = OPND_BITS;

  localparam logic [2:0] CFG_MEAS_VAR = 3'd0;
  localparam logic [2:0] CFG_PROC_VAR = 3'd1;
  localparam logic [2:0] CFG_INIT_VAR = 3'd2;

  typedef enum logic [1:0] {
    MDU_MUL = 2'b01,
    MDU_DIV = 2'b10
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_req_t;

  typedef enum logic [3:0] {
    ST_VEL_DT  = 4'd0,
    ST_DT_SQ   = 4'd1,
    ST_COV_DT  = 4'd2,
    ST_VV_DD   = 4'd3,
    ST_VV_DT   = 4'd4,
    ST_RECIP   = 4'd5,
    ST_GAIN_P  = 4'd6,
    ST_GAIN_V  = 4'd7,
    ST_UPD_POS = 4'd8,
    ST_UPD_VEL = 4'd9,
    ST_UPD_COV = 4'd10,
    ST_UPD_VP  = 4'd11,
    ST_UPD_VV  = 4'd12
  } step_t;

  typedef struct packed {
    logic                 clip;
    logic [WORD_BITS-1:0] val;
  } sat_t;

  function automatic logic [WIDE_BITS-1:0] sx(input logic [WORD_BITS-1:0] x);
    return {{(WIDE_BITS-WORD_BITS){x[WORD_BITS-1]}}, x};
  endfunction

  function automatic logic [WIDE_BITS-1:0] zx(input logic [WORD_BITS-1:0] x);
    return {{(WIDE_BITS-WORD_BITS){1'b0}}, x};
  endfunction

  function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] x);
    return x[WORD_BITS-1] ? (~x + 1'b1) : x;
  endfunction

  // clip a two's complement wide value to the signed word range
  function automatic sat_t sat_s(input logic [WIDE_BITS-1:0] x);
    sat_t r;
    if ((&x[WIDE_BITS-1:WORD_BITS-1]) || !(|x[WIDE_BITS-1:WORD_BITS-1])) begin
      r.clip = 1'b0;
      r.val  = x[WORD_BITS-1:0];
    end else begin
      r.clip = 1'b1;
      r.val  = x[WIDE_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                              : {1'b0, {(WORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  // clip to the unsigned word range
  function automatic sat_t sat_u(input logic [WIDE_BITS-1:0] x);
    sat_t r;
    if (x[WIDE_BITS-1]) begin
      r.clip = 1'b1;
      r.val  = '0;
    end else if (|x[WIDE_BITS-2:WORD_BITS]) begin
      r.clip = 1'b1;
      r.val  = '1;
    end else begin
      r.clip = 1'b0;
      r.val  = x[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/kcvt_mdu.sv -----
module kcvt_mdu (
  input  logic                                  clk,
  input  logic                                  rst,
  input  kcvt_pkg::mdu_req_t                    req,
  input  logic [kcvt_pkg::OPND_BITS-1:0]        a,
  input  logic [kcvt_pkg::OPND_BITS-1:0]        b,
  output logic                                  done,
  output logic [kcvt_pkg::PROD_BITS-1:0]        result
);
  import kcvt_pkg::*;

  logic                   busy;
  mdu_op_t                op;
  logic [5:0]             cnt;
  logic [OPND_BITS-1:0]   opa;
  logic [OPND_BITS-1:0]   opb;
  logic [PROD_BITS-1:0]   acc;
  logic [OPND_BITS-1:0]   rem;
  logic [OPND_BITS-1:0]   quo;

  logic [OPND_BITS+MUL_DIGIT-1:0] pp;
  logic [OPND_BITS:0]             rsh;
  logic [OPND_BITS:0]             rdif;

  assign pp   = opa * opb[OPND_BITS-1 -: MUL_DIGIT];
  assign rsh  = {rem, 1'b0};
  assign rdif = rsh - {1'b0, opb};

  assign result = (op == MDU_DIV) ? {{(PROD_BITS-OPND_BITS){1'b0}}, quo} : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= MDU_MUL;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if ((op == MDU_MUL && cnt == 6'(MUL_STEPS - 1)) ||
            (op == MDU_DIV && cnt == 6'(DIV_STEPS - 1))) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: MSB-first radix-256 multiply, restoring reciprocal divide
  always_ff @(posedge clk) begin
    if (req.start) begin
      opa <= a;
      opb <= b;
      acc <= '0;
      // remainder after the leading all-zero quotient bits of 2^126 / d
      rem <= {2'b01, {(OPND_BITS-2){1'b0}}};
      quo <= '0;
    end else if (busy) begin
      if (op == MDU_MUL) begin
        acc <= (acc << MUL_DIGIT) + PROD_BITS'(pp);
        opb <= opb << MUL_DIGIT;
      end else begin
        if (!rdif[OPND_BITS]) begin
          rem <= rdif[OPND_BITS-1:0];
          quo <= {quo[OPND_BITS-2:0], 1'b1};
        end else begin
          rem <= rsh[OPND_BITS-1:0];
          quo <= {quo[OPND_BITS-2:0], 1'b0};
        end
      end
    end
  end

endmodule

// ----- sv/kalman_const_velocity_tracker_top.sv -----
// Single-axis constant-velocity Kalman tracker, Q16.16 fixed point. An
// initialise item (mode 0) loads position, zero velocity and the initial
// variance; its result goes through S_OUT, which waits while an untaken
// result is held, into the output register, and the input is ready again
// once that register is loaded. A predict/correct item (mode 1) runs
// through one shared multiply/divide unit: twelve 64x64 products at 8 bits
// a cycle, each with an issue and a post-processing state, one 64-step
// reciprocal division and a normalising shift. When the innovation variance
// is zero the item stops after five products. The input is not ready while
// an item is in work; a result waits in the output register and the next
// item may be taken meanwhile. Every clip, and a zero innovation variance,
// raises saturated. Configuration writes are always taken (cfg_ready tied
// high); indices beyond the list are dropped.
module kalman_const_velocity_tracker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [15:0] time_step,
  input  logic [31:0] measured_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] position_estimate,
  output logic [31:0] velocity_estimate,
  output logic        saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import kcvt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_WAIT  = 6'b000100,
    S_POST  = 6'b001000,
    S_NORM  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  step_t  step;

  // configuration
  logic [WORD_BITS-1:0] meas_var, proc_var, init_var;

  // filter state
  logic [WORD_BITS-1:0] position, velocity, cov_cross, var_position, var_velocity;

  // per-item working registers
  logic [WORD_BITS-1:0] meas, ps, psv, pss, pvv;
  logic [DT_BITS-1:0]   t, dd;
  logic [33:0]          sc;
  logic [OPND_BITS-1:0] sn, recip, kp, kv;
  logic [5:0]           norm;
  logic                 sflag;

  // shared unit
  mdu_req_t             mreq;
  logic [OPND_BITS-1:0] ma, mb;
  logic                 mdone;
  logic [PROD_BITS-1:0] prod;

  kcvt_mdu u_mdu (
    .clk    (clk),
    .rst    (rst),
    .req    (mreq),
    .a      (ma),
    .b      (mb),
    .done   (mdone),
    .result (prod)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // innovation, 33-bit signed
  logic [32:0] diff, diff_mag;
  assign diff     = {meas[31], meas} - {ps[31], ps};
  assign diff_mag = diff[32] ? (~diff + 1'b1) : diff;

  // operand select for the step in hand
  always_comb begin
    mreq.start = (state == S_ISSUE);
    mreq.op    = MDU_MUL;
    ma         = '0;
    mb         = '0;
    case (step)
      ST_VEL_DT:  begin ma = 64'(mag(velocity));  mb = 64'(t); end
      ST_DT_SQ:   begin ma = 64'(t);              mb = 64'(t); end
      ST_COV_DT:  begin ma = 64'(mag(cov_cross)); mb = 64'(t); end
      ST_VV_DD:   begin ma = 64'(var_velocity);   mb = 64'(dd); end
      ST_VV_DT:   begin ma = 64'(var_velocity);   mb = 64'(t); end
      ST_RECIP:   begin mreq.op = MDU_DIV;        mb = sn; end
      ST_GAIN_P:  begin ma = 64'(pss);            mb = recip; end
      ST_GAIN_V:  begin ma = 64'(mag(psv));       mb = recip; end
      ST_UPD_POS: begin ma = kp;                  mb = 64'(diff_mag); end
      ST_UPD_VEL: begin ma = kv;                  mb = 64'(diff_mag); end
      ST_UPD_COV: begin ma = kp;                  mb = 64'(mag(psv)); end
      ST_UPD_VP:  begin ma = kp;                  mb = 64'(pss); end
      ST_UPD_VV:  begin ma = kv;                  mb = 64'(mag(psv)); end
      default:    begin ma = '0;                  mb = '0; end
    endcase
  end

  // rounding shifts of the product: by the time-step format, by the gain
  // format, and by the gain normalisation (94 - norm, 31..63)
  logic [PROD_BITS-1:0] rnd16, rnd32, rndg;
  logic [6:0]           gsh;
  assign gsh   = 7'(RECIP_SHIFT - GAIN_BITS) - {1'b0, norm};
  assign rnd16 = (prod + (PROD_BITS'(1) << (DT_BITS - 1))) >> DT_BITS;
  assign rnd32 = (prod + (PROD_BITS'(1) << (GAIN_BITS - 1))) >> GAIN_BITS;
  assign rndg  = (prod + (PROD_BITS'(1) << (gsh - 7'd1))) >> gsh;

  // prediction terms
  logic [WIDE_BITS-1:0] r16w, sv_w, sc_w, sc_x;
  sat_t                 ps_sat, pss_sat, psv_sat, pvv_sat;
  logic [32:0]          s_sum;
  assign r16w    = rnd16[WIDE_BITS-1:0];
  assign sv_w    = velocity[31] ? (~r16w + 1'b1) : r16w;
  assign sc_w    = cov_cross[31] ? (~r16w + 1'b1) : r16w;
  assign sc_x    = {{(WIDE_BITS-34){sc[33]}}, sc};
  assign ps_sat  = sat_s(sx(position) + sv_w);
  assign pss_sat = sat_u(zx(var_position) + (sc_x << 1) + r16w);
  assign psv_sat = sat_s(sx(cov_cross) + r16w);
  assign pvv_sat = sat_u(zx(var_velocity) + zx(proc_var));
  assign s_sum   = {1'b0, pss} + {1'b0, meas_var};

  // correction terms: gain times value, limited to 2^62
  localparam logic [WIDE_BITS-1:0] TERM_LIMIT = WIDE_BITS'(1) << 62;
  logic                 tclip, tneg, tadd;
  logic [WIDE_BITS-1:0] tmag, tsgn, ubase, usum;
  sat_t                 upd_s, upd_u;
  assign tclip = (|rnd32[PROD_BITS-1:WIDE_BITS]) || (rnd32[WIDE_BITS-1:0] > TERM_LIMIT);
  assign tmag  = tclip ? TERM_LIMIT : rnd32[WIDE_BITS-1:0];

  always_comb begin
    tneg  = 1'b0;
    tadd  = 1'b0;
    ubase = '0;
    case (step)
      ST_UPD_POS: begin tneg = diff[32];           tadd = 1'b1; ubase = sx(ps); end
      ST_UPD_VEL: begin tneg = psv[31] ^ diff[32]; tadd = 1'b1; ubase = sx(velocity); end
      ST_UPD_COV: begin tneg = psv[31];            ubase = sx(psv); end
      ST_UPD_VP:  begin tneg = 1'b0;               ubase = zx(pss); end
      ST_UPD_VV:  begin tneg = 1'b0;               ubase = zx(pvv); end
      default:    begin tneg = 1'b0;               ubase = '0; end
    endcase
  end

  assign tsgn  = tneg ? (~tmag + 1'b1) : tmag;
  assign usum  = tadd ? (ubase + tsgn) : (ubase - tsgn);
  assign upd_s = sat_s(usum);
  assign upd_u = sat_u(usum);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      meas_var <= 32'd65536;
      proc_var <= 32'd65536;
      init_var <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MEAS_VAR: meas_var <= cfg_data;
        CFG_PROC_VAR: proc_var <= cfg_data;
        CFG_INIT_VAR: init_var <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= ST_VEL_DT;
      out_valid    <= 1'b0;
      position     <= '0;
      velocity     <= '0;
      cov_cross    <= '0;
      var_position <= '0;
      var_velocity <= '0;
      sflag        <= 1'b0;
    end else begin
      // a result loaded in S_OUT keeps out_valid high
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sflag <= 1'b0;
            meas  <= measured_position;
            t     <= time_step;
            if (!mode) begin
              position     <= measured_position;
              velocity     <= '0;
              cov_cross    <= '0;
              var_position <= init_var;
              var_velocity <= init_var;
              state        <= S_OUT;
            end else begin
              step  <= ST_VEL_DT;
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (mdone) state <= S_POST;
        end
        S_POST: begin
          step <= step_t'(step + 4'd1);
          case (step)
            ST_VEL_DT: begin
              ps    <= ps_sat.val;
              sflag <= sflag | ps_sat.clip;
              state <= S_ISSUE;
            end
            ST_DT_SQ: begin
              dd    <= rnd16[DT_BITS-1:0];
              state <= S_ISSUE;
            end
            ST_COV_DT: begin
              sc    <= sc_w[33:0];
              state <= S_ISSUE;
            end
            ST_VV_DD: begin
              pss   <= pss_sat.val;
              sflag <= sflag | pss_sat.clip;
              state <= S_ISSUE;
            end
            ST_VV_DT: begin
              psv <= psv_sat.val;
              pvv <= pvv_sat.val;
              if (s_sum == '0) begin
                // zero divisor: prediction becomes the new state
                position     <= ps;
                var_position <= pss;
                cov_cross    <= psv_sat.val;
                var_velocity <= pvv_sat.val;
                sflag        <= 1'b1;
                state        <= S_OUT;
              end else begin
                sflag <= sflag | psv_sat.clip | pvv_sat.clip;
                sn    <= {s_sum, 31'b0};
                norm  <= 6'd31;
                state <= S_NORM;
              end
            end
            ST_RECIP: begin
              recip <= prod[OPND_BITS-1:0];
              state <= S_ISSUE;
            end
            ST_GAIN_P: begin
              kp    <= rndg[OPND_BITS-1:0];
              sflag <= sflag | (|rndg[PROD_BITS-1:OPND_BITS]);
              state <= S_ISSUE;
            end
            ST_GAIN_V: begin
              kv    <= rndg[OPND_BITS-1:0];
              sflag <= sflag | (|rndg[PROD_BITS-1:OPND_BITS]);
              state <= S_ISSUE;
            end
            ST_UPD_POS: begin
              position <= upd_s.val;
              sflag    <= sflag | tclip | upd_s.clip;
              state    <= S_ISSUE;
            end
            ST_UPD_VEL: begin
              velocity <= upd_s.val;
              sflag    <= sflag | tclip | upd_s.clip;
              state    <= S_ISSUE;
            end
            ST_UPD_COV: begin
              cov_cross <= upd_s.val;
              sflag     <= sflag | tclip | upd_s.clip;
              state     <= S_ISSUE;
            end
            ST_UPD_VP: begin
              var_position <= upd_u.val;
              sflag        <= sflag | tclip | upd_u.clip;
              state        <= S_ISSUE;
            end
            ST_UPD_VV: begin
              var_velocity <= upd_u.val;
              sflag        <= sflag | tclip | upd_u.clip;
              state        <= S_OUT;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_NORM: begin
          // one bit a cycle until the divisor's top bit is set
          if (sn[OPND_BITS-1]) begin
            step  <= ST_RECIP;
            state <= S_ISSUE;
          end else begin
            sn   <= sn << 1;
            norm <= norm + 6'd1;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            position_estimate <= position;
            velocity_estimate <= velocity;
            saturated         <= sflag;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/tb_kalman_const_velocity_tracker_top.sv -----
module tb_kalman_const_velocity_tracker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kcvt_pkg::*;

  // Unused register index; the block must drop a write to it
  localparam logic [2:0] CFG_SPARE = 3'd5;

  localparam logic MODE_INIT    = 1'b0;
  localparam logic MODE_PREDICT = 1'b1;

  // Watchdog: cycles with no transfer on any channel. The limit covers the
  // slowest correct item plus a receiver stall burst and the hold-off.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF       = 400;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int STEADY_ITEMS   = 150;

  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam longint UMAX = 64'sd4294967295;
  localparam longint unsigned TERM_CAP = 64'd1 << 62;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        mode;
  logic [15:0] time_step;
  logic [31:0] measured_position;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] position_estimate;
  logic [31:0] velocity_estimate;
  logic        saturated;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  kalman_const_velocity_tracker_top DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .mode              (mode),
    .time_step         (time_step),
    .measured_position (measured_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .position_estimate (position_estimate),
    .velocity_estimate (velocity_estimate),
    .saturated         (saturated),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] vel;
    logic        sat;
  } estimate_t;

  estimate_t estimates_due[$];

  // Tracker state mirrored on the bench side
  longint          trk_pos, trk_vel, trk_cross;
  longint unsigned trk_var_pos, trk_var_vel;
  longint unsigned meas_var, proc_var, init_var;

  int  errors;
  int  idle_cycles;
  bit  idling_on;   // random gaps on both sides
  bit  hold_req;    // receiver holds out_ready low for the HOLD_OFF length, then clears

  // Clock: 8 ns period
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Fixed-point helpers for the tracker arithmetic
  // ---------------------------------------------------------------------
  function automatic longint unsigned mag64(longint x);
    return x < 0 ? 64'd0 - longint'(x) : x;
  endfunction

  function automatic longint signed_of(bit neg, longint unsigned m);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // x times an unsigned Q0.16 factor, rounded half away from zero
  function automatic longint scale_by_dt(longint x, longint unsigned t);
    longint unsigned m;
    m = (mag64(x) * t + 64'd32768) >> 16;
    return signed_of(x < 0, m);
  endfunction

  function automatic longint clip_signed(longint x, inout bit f);
    if (x > SMAX) begin
      f = 1'b1;
      return SMAX;
    end
    if (x < SMIN) begin
      f = 1'b1;
      return SMIN;
    end
    return x;
  endfunction

  function automatic longint unsigned clip_var(longint x, inout bit f);
    if (x < 0) begin
      f = 1'b1;
      return 0;
    end
    if (x > UMAX) begin
      f = 1'b1;
      return UMAX;
    end
    return x;
  endfunction

  // round half up on a 128-bit magnitude then shift; wraps like the hardware
  function automatic logic [127:0] round_shift(logic [127:0] w, int sh);
    w = w + (128'd1 << (sh - 1));
    return w >> sh;
  endfunction

  function automatic longint unsigned gain_from_recip(longint x, longint unsigned recip,
                                                      int norm, inout bit f);
    logic [127:0] a, b, w;
    a = 128'(mag64(x));
    b = 128'(recip);
    w = round_shift(a * b, RECIP_SHIFT - norm - GAIN_BITS);
    if (w[127:64] != 0) begin
      f = 1'b1;
      return 64'hFFFF_FFFF_FFFF_FFFF;
    end
    return w[63:0];
  endfunction

  function automatic longint gain_times(bit gneg, longint unsigned g, longint x, inout bit f);
    logic [127:0] a, b, w;
    longint unsigned m;
    a = 128'(g);
    b = 128'(mag64(x));
    w = round_shift(a * b, GAIN_BITS);
    if (w > 128'(TERM_CAP)) begin
      f = 1'b1;
      m = TERM_CAP;
    end else begin
      m = w[63:0];
    end
    return signed_of(gneg != (x < 0), m);
  endfunction

  // Advance the mirrored tracker by one item and queue the estimate due
  task automatic track_item(logic m, logic [15:0] dt, logic [31:0] p);
    bit              f;
    longint          meas, ps, pv, psv, diff;
    longint unsigned t, dd, pss, pvv, s, sn, recip, kp, kv;
    logic [127:0]    num;
    int              norm;
    bit              kvneg;
    estimate_t       e;
    f    = 1'b0;
    meas = longint'(signed'(p));
    if (m == MODE_INIT) begin
      trk_pos     = meas;
      trk_vel     = 0;
      trk_var_pos = init_var;
      trk_var_vel = init_var;
      trk_cross   = 0;
    end else begin
      t   = 64'(dt);
      dd  = (t * t + 64'd32768) >> 16;
      ps  = clip_signed(trk_pos + scale_by_dt(trk_vel, t), f);
      pv  = trk_vel;
      pss = clip_var(longint'(trk_var_pos) + 2 * scale_by_dt(trk_cross, t)
                     + scale_by_dt(longint'(trk_var_vel), dd), f);
      psv = clip_signed(trk_cross + scale_by_dt(longint'(trk_var_vel), t), f);
      pvv = clip_var(longint'(trk_var_vel + proc_var), f);
      s   = pss + meas_var;
      if (s == 0) begin
        // nothing to divide by: keep the prediction
        f           = 1'b1;
        trk_pos     = ps;
        trk_vel     = pv;
        trk_var_pos = pss;
        trk_cross   = psv;
        trk_var_vel = pvv;
      end else begin
        norm = 0;
        sn   = s;
        while (sn[63] == 1'b0) begin
          sn = sn << 1;
          norm++;
        end
        num   = 128'd1 << RECIP_SHIFT;
        num   = num / {64'd0, sn};
        recip = num[63:0];
        kvneg = psv < 0;
        diff  = meas - ps;
        kp    = gain_from_recip(longint'(pss), recip, norm, f);
        kv    = gain_from_recip(psv, recip, norm, f);
        trk_pos     = clip_signed(ps + gain_times(1'b0, kp, diff, f), f);
        trk_vel     = clip_signed(pv + gain_times(kvneg, kv, diff, f), f);
        trk_cross   = clip_signed(psv - gain_times(1'b0, kp, psv, f), f);
        trk_var_pos = clip_var(longint'(pss) - gain_times(1'b0, kp, longint'(pss), f), f);
        trk_var_vel = clip_var(longint'(pvv) - gain_times(kvneg, kv, psv, f), f);
      end
    end
    e.pos = trk_pos[31:0];
    e.vel = trk_vel[31:0];
    e.sat = f;
    estimates_due.push_back(e);
  endtask

  // ---------------------------------------------------------------------
  // Sender: payload and valid change at the falling edge; valid is left
  // high after a transfer so that back-to-back items need no extra step
  // ---------------------------------------------------------------------
  task automatic send_item(logic m, logic [15:0] dt, logic [31:0] p);
    int gap;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap      = $urandom_range(1, 11);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode              = m;
    time_step         = dt;
    measured_position = p;
    in_valid          = 1'b1;
    do @(posedge clk); while (!in_ready);
    track_item(m, dt, p);
  endtask

  // Drop valid and wait until every estimate due has been taken
  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (estimates_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register writes only with the block idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    drain();
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MEAS_VAR: meas_var = data;
      CFG_PROC_VAR: proc_var = data;
      CFG_INIT_VAR: init_var = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(logic [31:0] r, logic [31:0] q, logic [31:0] p0);
    write_reg(CFG_MEAS_VAR, r);
    write_reg(CFG_PROC_VAR, q);
    write_reg(CFG_INIT_VAR, p0);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, and a long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    int burst;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        burst     = $urandom_range(1, 11);
        out_ready = 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checking against the oldest estimate due
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    estimate_t e;
    if (!rst && out_valid && out_ready) begin
      if (estimates_due.size() == 0) begin
        report_mismatch("unexpected transfer", position_estimate, 32'h0);
      end else begin
        e = estimates_due.pop_front();
        if (position_estimate !== e.pos)
          report_mismatch("position_estimate", position_estimate, e.pos);
        if (velocity_estimate !== e.vel)
          report_mismatch("velocity_estimate", velocity_estimate, e.vel);
        if (saturated !== e.sat)
          report_mismatch("saturated", {31'd0, saturated}, {31'd0, e.sat});
      end
    end
  end

  // Watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Predict straight out of reset with zero measurement variance: the
  // innovation variance is zero, so the prediction stands and the flag is set
  task automatic test_zero_divisor;
    write_reg(CFG_MEAS_VAR, 32'd0);
    send_item(MODE_PREDICT, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(MODE_PREDICT, 16'h0000, 32'h8000_0000);
    write_reg(CFG_MEAS_VAR, 32'h0001_0000);
    // predict on reset-like state but with a nonzero divisor
    send_item(MODE_PREDICT, 16'h8000, 32'h0001_0000);
  endtask

  // Initialise ignores time_step; extremes of the position field
  task automatic test_initialise;
    send_item(MODE_INIT, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(MODE_INIT, 16'h0000, 32'h8000_0000);
    send_item(MODE_INIT, 16'h1234, 32'h0000_0000);
    send_item(MODE_PREDICT, 16'h0000, 32'h0000_0000);
  endtask

  // Large jumps and extreme registers to drive every clip
  task automatic test_clipping;
    send_item(MODE_INIT, 16'h0000, 32'h8000_0000);
    send_item(MODE_PREDICT, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(MODE_PREDICT, 16'hFFFF, 32'h8000_0000);
    send_item(MODE_PREDICT, 16'hFFFF, 32'h7FFF_FFFF);
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_INIT, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(MODE_PREDICT, 16'hFFFF, 32'h8000_0000);
    send_item(MODE_PREDICT, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(MODE_PREDICT, 16'h0001, 32'h0000_0000);
    // all zero: covariance collapses and the divisor is zero after init
    set_regs(32'd0, 32'd0, 32'd0);
    send_item(MODE_INIT, 16'h0000, 32'h0010_0000);
    send_item(MODE_PREDICT, 16'h4000, 32'h0020_0000);
    // a write to an index beyond the list must change nothing
    write_reg(CFG_SPARE, 32'hDEAD_BEEF);
    send_item(MODE_PREDICT, 16'hFFFF, 32'hFFF0_0000);
    set_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
  endtask

  // Receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure;
    send_item(MODE_INIT, 16'h0000, 32'h0003_0000);
    hold_req = 1'b1;
    repeat (6) send_item(MODE_PREDICT, 16'h1000, $urandom_range(0, 32'h0008_0000));
  endtask

  // Well-formed tracks with random content, plus fully random noise items
  task automatic run_tracks(int count);
    int          sent, len;
    longint      truth_pos, truth_vel;
    logic [15:0] dt;
    logic [31:0] noise;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'($urandom_range(0, 1)), 16'($urandom), $urandom);
        sent++;
      end else begin
        truth_pos = $urandom_range(0, 1) ? longint'(signed'($urandom))
                                         : longint'(signed'($urandom)) >>> 8;
        truth_vel = longint'(signed'($urandom)) >>> $urandom_range(4, 14);
        send_item(MODE_INIT, 16'($urandom), truth_pos[31:0]);
        sent++;
        len = $urandom_range(3, 30);
        repeat (len) begin
          dt = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16384));
          truth_pos = truth_pos + ((truth_vel * longint'(dt)) >>> 16);
          noise     = $urandom;
          send_item(MODE_PREDICT, dt,
                    32'(truth_pos + (longint'(signed'(noise)) >>> $urandom_range(10, 24))));
          sent++;
        end
      end
    end
  endtask

  task automatic random_register_phase;
    case ($urandom_range(0, 4))
      0: set_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      1: set_regs($urandom_range(1, 32'h0000_1000), $urandom_range(0, 32'h0000_1000),
                  $urandom_range(0, 32'h0100_0000));
      2: set_regs(32'hFFFF_FFFF, $urandom_range(0, 32'h0010_0000), 32'hFFFF_FFFF);
      3: set_regs(32'd0, $urandom, $urandom);
      default: set_regs($urandom, $urandom, $urandom);
    endcase
  endtask

  task automatic test_random;
    int phase;
    for (phase = 0; phase < 8; phase++) begin
      random_register_phase();
      run_tracks(RANDOM_ITEMS / 8);
    end
  endtask

  // Last stretch: no gaps on either side
  task automatic test_steady;
    drain();
    idling_on = 1'b0;
    set_regs(32'h0000_4000, 32'h0000_0100, 32'h0010_0000);
    run_tracks(STEADY_ITEMS);
  endtask

  initial begin
    rst               = 1'b1;
    in_valid          = 1'b0;
    mode              = MODE_INIT;
    time_step         = '0;
    measured_position = '0;
    cfg_valid         = 1'b0;
    cfg_index         = CFG_MEAS_VAR;
    cfg_data          = '0;
    errors            = 0;
    idling_on         = 1'b1;
    hold_req          = 1'b0;
    trk_pos           = 0;
    trk_vel           = 0;
    trk_cross         = 0;
    trk_var_pos       = 0;
    trk_var_vel       = 0;
    meas_var          = 64'd65536;
    proc_var          = 64'd65536;
    init_var          = 64'd65536;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_zero_divisor();
    test_initialise();
    test_clipping();
    test_backpressure();
    test_random();
    test_steady();

    drain();
    // let any stray transfer show up before the verdict
    repeat (300) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
